// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

   localparam int BitsPerByte = 8;
   localparam int CountW      = $clog2(BitsPerByte + 1);
   localparam int QueueDepth  = 2;

   localparam logic [7:0] DelayReset = 8'd6;

   localparam logic [2:0] ActTick  = 3'd0;
   localparam logic [2:0] ActStart = 3'd1;
   localparam logic [2:0] ActStop  = 3'd2;
   localparam logic [2:0] ActWrite = 3'd3;
   localparam logic [2:0] ActRead  = 3'd4;
   localparam logic [2:0] ActWack  = 3'd5;
   localparam logic [2:0] ActSack  = 3'd6;
   localparam logic [2:0] ActSpare = 3'd7;

   typedef enum logic [6:0] {
      OP_IDLE  = 7'b0000001,
      OP_START = 7'b0000010,
      OP_STOP  = 7'b0000100,
      OP_WRITE = 7'b0001000,
      OP_READ  = 7'b0010000,
      OP_WACK  = 7'b0100000,
      OP_SACK  = 7'b1000000
   } op_type;

   localparam logic [1:0] Phase0 = 2'd0;
   localparam logic [1:0] Phase1 = 2'd1;
   localparam logic [1:0] Phase2 = 2'd2;
   localparam logic [1:0] Phase3 = 2'd3;

   typedef struct packed {
      logic       is_cmd;
      op_type     op;
      logic [7:0] tx_data;
      logic       ack_value;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

// ===== src/i2cm_req_if.sv =====
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_data;
   logic       ack_value;
   logic       sda_in;

   modport source (output valid, output action, output tx_data, output ack_value,
                   output sda_in, input ready);
   modport sink (input valid, input action, input tx_data, input ack_value,
                 input sda_in, output ready);
endinterface

// ===== src/i2cm_rsp_if.sv =====
interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic [7:0] rx_data;
   logic       ack_seen;
   logic       done_res;
   logic       rejected;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output rx_data, output ack_seen, output done_res, output rejected,
                   input ready);
   modport sink (input valid, input scl_out, input sda_out, input busy_res,
                 input rx_data, input ack_seen, input done_res, input rejected,
                 output ready);
endinterface

// ===== src/i2cm_front.sv =====
module i2cm_front
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic           clock,
   input  logic           reset,
   i2cm_req_if.sink       req_port,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0]   PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CountW-1:0] CountFull = CountW'(QUEUE_DEPTH);

   item_type          queue_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   item_type          item_in;
   logic              push;
   logic              is_cmd;

   always_comb begin
      is_cmd = (req_port.action != ActTick) && (req_port.action != ActSpare);
      item_in.is_cmd    = is_cmd;
      item_in.tx_data   = req_port.tx_data;
      item_in.ack_value = req_port.ack_value;
      item_in.sda_in    = req_port.sda_in;
      case (req_port.action)
         ActStart: item_in.op = OP_START;
         ActStop:  item_in.op = OP_STOP;
         ActWrite: item_in.op = OP_WRITE;
         ActRead:  item_in.op = OP_READ;
         ActWack:  item_in.op = OP_WACK;
         ActSack:  item_in.op = OP_SACK;
         default:  item_in.op = OP_IDLE;
      endcase
   end

   assign req_port.ready = (count_ff != CountFull);
   assign push = req_port.valid && req_port.ready;

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== src/i2cm_back.sv =====
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  queue_head_type head,
   output logic           pop,
   i2cm_rsp_if.source     rsp_port
);

   logic [7:0]        delay_ff;
   op_type            op_ff, op_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CountW-1:0] bit_ff, bit_in;
   logic [7:0]        wait_ff, wait_in;
   logic [7:0]        shift_ff, shift_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in;
   logic              ack_ff, ack_in;
   logic [7:0]        rx_ff, rx_in;
   logic              done_in;
   logic              rej_in;

   logic              rsp_valid_ff;
   logic              rsp_busy_ff;
   logic              rsp_done_ff;
   logic              rsp_rej_ff;

   logic [7:0]        dly;
   logic              run;
   logic              fin;
   logic [CountW-1:0] bit_next;
   item_type          it;

   assign it  = head.item;
   assign dly = (delay_ff == '0) ? 8'd1 : delay_ff;
   assign pop = head.valid && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      wait_in  = wait_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      done_in  = 1'b0;
      rej_in   = 1'b0;
      run      = 1'b0;
      fin      = 1'b0;
      bit_next = bit_ff + 1'b1;

      if (op_ff != OP_IDLE) begin
         rej_in = it.is_cmd;
         if (wait_ff != '0) begin
            wait_in = wait_ff - 1'b1;
         end
         run = (wait_in == '0);
      end else if (it.is_cmd) begin
         op_in    = it.op;
         phase_in = Phase0;
         bit_in   = '0;
         wait_in  = '0;
         case (it.op)
            OP_WRITE: shift_in = it.tx_data;
            OP_READ:  shift_in = '0;
            OP_SACK:  shift_in = {7'd0, it.ack_value};
            default:  shift_in = shift_ff;
         endcase
         run = 1'b1;
      end

      if (run) begin
         bit_next = bit_in + 1'b1;
         case (op_in)
            OP_START: begin
               if (phase_in == Phase0) begin
                  sda_in = 1'b1; scl_in = 1'b1; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  sda_in = 1'b0; wait_in = dly; phase_in = Phase2;
               end else begin
                  scl_in = 1'b0; fin = 1'b1;
               end
            end
            OP_STOP: begin
               if (phase_in == Phase0) begin
                  sda_in = 1'b0; scl_in = 1'b1; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  sda_in = 1'b1; wait_in = dly; phase_in = Phase2;
               end else begin
                  fin = 1'b1;
               end
            end
            OP_WRITE: begin
               if (phase_in == Phase0) begin
                  scl_in = 1'b0; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  sda_in = shift_in[7]; wait_in = dly; phase_in = Phase2;
               end else if (phase_in == Phase2) begin
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_next;
                  wait_in  = dly;
                  phase_in = (bit_next < CountW'(BitsPerByte)) ? Phase0 : Phase3;
               end else begin
                  scl_in = 1'b0; fin = 1'b1;
               end
            end
            OP_READ: begin
               if (phase_in == Phase0) begin
                  scl_in = 1'b1; sda_in = 1'b1; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  shift_in = {shift_in[6:0], it.sda_in};
                  scl_in   = 1'b0;
                  bit_in   = bit_next;
                  wait_in  = dly;
                  phase_in = (bit_next < CountW'(BitsPerByte)) ? Phase0 : Phase2;
               end else begin
                  rx_in = shift_in; fin = 1'b1;
               end
            end
            OP_WACK: begin
               if (phase_in == Phase0) begin
                  sda_in = 1'b1; scl_in = 1'b1; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  ack_in = it.sda_in; scl_in = 1'b0; wait_in = dly; phase_in = Phase2;
               end else begin
                  fin = 1'b1;
               end
            end
            OP_SACK: begin
               if (phase_in == Phase0) begin
                  scl_in = 1'b0; sda_in = shift_in[0]; wait_in = dly; phase_in = Phase1;
               end else if (phase_in == Phase1) begin
                  scl_in = 1'b1; wait_in = dly; phase_in = Phase2;
               end else if (phase_in == Phase2) begin
                  scl_in = 1'b0; sda_in = 1'b1; wait_in = dly; phase_in = Phase3;
               end else begin
                  fin = 1'b1;
               end
            end
            default: fin = 1'b1;
         endcase
         if (fin) begin
            op_in    = OP_IDLE;
            phase_in = Phase0;
            done_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DelayReset;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_IDLE;
         phase_ff <= Phase0;
         bit_ff   <= '0;
         wait_ff  <= '0;
         shift_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b1;
         rx_ff    <= '0;
      end else if (pop) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         wait_ff  <= wait_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_busy_ff <= (op_in != OP_IDLE);
         rsp_done_ff <= done_in;
         rsp_rej_ff  <= rej_in;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.scl_out  = scl_ff;
   assign rsp_port.sda_out  = sda_ff;
   assign rsp_port.busy_res = rsp_busy_ff;
   assign rsp_port.rx_data  = rx_ff;
   assign rsp_port.ack_seen = ack_ff;
   assign rsp_port.done_res = rsp_done_ff;
   assign rsp_port.rejected = rsp_rej_ff;

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// I2C master bit engine. Every transfer on req_port is one tick of the bus
// sequencer, optionally carrying a command (start, stop, write byte, read
// byte, wait ack, send ack) and always the sampled SDA level; every tick
// gives one transfer on rsp_port with the driven SCL/SDA, busy, last received
// byte, last ACK level, done and rejected. A command that arrives while one
// runs is dropped and flagged. Throughput is one item per clock while the
// receiver takes results, set by the sequencer that retires one tick per
// cycle; a request passes a small queue (QUEUE_DEPTH entries) and then the
// result register before it is offered on rsp_port. A stalled receiver
// holds the result register, and req_port drops ready once the queue is full.
// Write csr_wr_data (ticks per line wait, 0 acts as 1) only while no transfer
// is outstanding.
module i2c_master_bit_engine
   import i2cm_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   i2cm_req_if.sink    req_port,
   i2cm_rsp_if.source  rsp_port
);

   queue_head_type head;
   logic           pop;

   i2cm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .head     (head),
      .pop      (pop)
   );

   i2cm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .rsp_port    (rsp_port)
   );

endmodule

// ===== src/i2cm_checker.sv =====
module i2cm_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_busy,
   input logic rsp_done,
   input logic rsp_rej
);

   // hold a result until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> !rsp_busy)
      else $error("done with busy still set");

   a_rej_in_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rej |-> rsp_busy || rsp_done)
      else $error("reject outside a running command");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_busy  (rsp_port.busy_res),
   .rsp_done  (rsp_port.done_res),
   .rsp_rej   (rsp_port.rejected)
);

// ===== test/i2c_master_bit_engine_test.sv =====
`timescale 1ns / 1ps

module i2c_master_bit_engine_test;
   import i2cm_pkg::*;

   localparam logic [2:0] OpNone    = ActTick;
   localparam int         CycleLimit = 400000;
   localparam int         HoldOffLen = 400;

   localparam int SdaLow  = 0;
   localparam int SdaHigh = 1;
   localparam int SdaRand = 2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_data;
      logic       ack_value;
      logic       sda_in;
   } bus_cmd_type;

   typedef struct packed {
      logic [7:0] delay;
      logic [2:0] op;
      logic [1:0] phase;
      logic [3:0] bits;
      logic [7:0] wait_left;
      logic [7:0] shreg;
      logic       scl;
      logic       sda;
      logic       ack;
      logic [7:0] rx_hold;
      logic       done;
      logic       rej;
   } engine_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();

   i2c_master_bit_engine dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus)
   );

   bus_cmd_type feed_q[$];
   engine_type  outlook_q[$];
   engine_type  gen_state;
   engine_type  model_state;

   int gen_cnt;
   int checked_cnt;
   int mismatches;
   int cycle_cnt;
   int hold_offs_wanted;
   int hold_offs_done;
   int send_gap;
   int send_calm;
   int sink_stall;
   int sink_calm;
   int stall_draw;

   bus_cmd_type next_cmd;
   bus_cmd_type taken_cmd;
   engine_type  want;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic engine_type reset_engine();
      engine_type e;
      e = '0;
      e.delay = DelayReset;
      e.op    = OpNone;
      e.phase = Phase0;
      e.scl   = 1'b1;
      e.sda   = 1'b1;
      e.ack   = 1'b1;
      return e;
   endfunction

   function automatic engine_type hold_for(input engine_type e, input logic [1:0] nxt);
      e.wait_left = (e.delay == 8'd0) ? 8'd1 : e.delay;
      e.phase = nxt;
      return e;
   endfunction

   function automatic engine_type run_phase(input engine_type e, input logic sda_lvl);
      case (e.op)
         ActStart: begin
            if (e.phase == Phase0) begin
               e.sda = 1'b1;
               e.scl = 1'b1;
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.sda = 1'b0;
               e = hold_for(e, Phase2);
            end else begin
               e.scl = 1'b0;
               e.done = 1'b1;
            end
         end
         ActStop: begin
            if (e.phase == Phase0) begin
               e.sda = 1'b0;
               e.scl = 1'b1;
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.sda = 1'b1;
               e = hold_for(e, Phase2);
            end else begin
               e.done = 1'b1;
            end
         end
         ActWrite: begin
            if (e.phase == Phase0) begin
               e.scl = 1'b0;
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.sda = e.shreg[7];
               e = hold_for(e, Phase2);
            end else if (e.phase == Phase2) begin
               e.scl = 1'b1;
               e.shreg = {e.shreg[6:0], 1'b0};
               e.bits = e.bits + 4'd1;
               e = hold_for(e, (e.bits < BitsPerByte) ? Phase0 : Phase3);
            end else begin
               e.scl = 1'b0;
               e.done = 1'b1;
            end
         end
         ActRead: begin
            if (e.phase == Phase0) begin
               e.scl = 1'b1;
               e.sda = 1'b1;
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.shreg = {e.shreg[6:0], sda_lvl};
               e.scl = 1'b0;
               e.bits = e.bits + 4'd1;
               e = hold_for(e, (e.bits < BitsPerByte) ? Phase0 : Phase2);
            end else begin
               e.rx_hold = e.shreg;
               e.done = 1'b1;
            end
         end
         ActWack: begin
            if (e.phase == Phase0) begin
               e.sda = 1'b1;
               e.scl = 1'b1;
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.ack = sda_lvl;
               e.scl = 1'b0;
               e = hold_for(e, Phase2);
            end else begin
               e.done = 1'b1;
            end
         end
         ActSack: begin
            if (e.phase == Phase0) begin
               e.scl = 1'b0;
               e.sda = e.shreg[0];
               e = hold_for(e, Phase1);
            end else if (e.phase == Phase1) begin
               e.scl = 1'b1;
               e = hold_for(e, Phase2);
            end else if (e.phase == Phase2) begin
               e.scl = 1'b0;
               e.sda = 1'b1;
               e = hold_for(e, Phase3);
            end else begin
               e.done = 1'b1;
            end
         end
         default: e.done = 1'b1;
      endcase
      return e;
   endfunction

   // advance the engine by one transfer; the result lines are read from the new state
   function automatic engine_type step_engine(input engine_type e, input bus_cmd_type c);
      logic is_cmd;
      is_cmd = (c.action >= ActStart) && (c.action <= ActSack);
      e.done = 1'b0;
      e.rej = 1'b0;
      if (e.op != OpNone) begin
         if (is_cmd) e.rej = 1'b1;
         if (e.wait_left != 8'd0) e.wait_left = e.wait_left - 8'd1;
         if (e.wait_left == 8'd0) e = run_phase(e, c.sda_in);
      end else if (is_cmd) begin
         e.op = c.action;
         e.phase = Phase0;
         e.bits = 4'd0;
         e.wait_left = 8'd0;
         if (c.action == ActWrite) begin
            e.shreg = c.tx_data;
         end else if (c.action == ActRead) begin
            e.shreg = 8'd0;
         end else if (c.action == ActSack) begin
            e.shreg = {7'd0, c.ack_value};
         end
         e = run_phase(e, c.sda_in);
      end
      if (e.done) begin
         e.op = OpNone;
         e.phase = Phase0;
      end
      return e;
   endfunction

   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_field(input string fname, input int unsigned exp_val,
                                       input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", fname, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.action <= ActTick;
         req_bus.tx_data <= 8'd0;
         req_bus.ack_value <= 1'b0;
         req_bus.sda_in <= 1'b0;
         send_gap <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (feed_q.size() > 0) begin
            next_cmd = feed_q.pop_front();
            req_bus.action <= next_cmd.action;
            req_bus.tx_data <= next_cmd.tx_data;
            req_bus.ack_value <= next_cmd.ack_value;
            req_bus.sda_in <= next_cmd.sda_in;
            req_bus.valid <= 1'b1;
            send_gap <= draw_gap(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall <= 0;
      end else if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_offs_done < hold_offs_wanted) begin
         hold_offs_done <= hold_offs_done + 1;
         sink_stall <= HoldOffLen - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_draw = draw_gap(sink_calm);
         if (stall_draw > 0) begin
            sink_stall <= stall_draw - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken_cmd.action = req_bus.action;
            taken_cmd.tx_data = req_bus.tx_data;
            taken_cmd.ack_value = req_bus.ack_value;
            taken_cmd.sda_in = req_bus.sda_in;
            model_state = step_engine(model_state, taken_cmd);
            outlook_q.push_back(model_state);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (outlook_q.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatches++;
            end else begin
               want = outlook_q.pop_front();
               check_field("scl_out", 32'(want.scl), 32'(rsp_bus.scl_out));
               check_field("sda_out", 32'(want.sda), 32'(rsp_bus.sda_out));
               check_field("busy_res", 32'(want.op != OpNone), 32'(rsp_bus.busy_res));
               check_field("rx_data", 32'(want.rx_hold), 32'(rsp_bus.rx_data));
               check_field("ack_seen", 32'(want.ack), 32'(rsp_bus.ack_seen));
               check_field("done_res", 32'(want.done), 32'(rsp_bus.done_res));
               check_field("rejected", 32'(want.rej), 32'(rsp_bus.rejected));
            end
            checked_cnt++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_item(input bus_cmd_type c);
      feed_q.push_back(c);
      gen_state = step_engine(gen_state, c);
      gen_cnt++;
   endtask

   task automatic run_to_idle(input int sda_mode);
      bus_cmd_type c;
      while (gen_state.op != OpNone) begin
         c.action = ActTick;
         c.tx_data = 8'($urandom);
         c.ack_value = 1'($urandom);
         c.sda_in = (sda_mode == SdaRand) ? 1'($urandom) : (sda_mode == SdaHigh);
         push_item(c);
      end
   endtask

   task automatic issue(input logic [2:0] act, input logic [7:0] tx, input logic ackv,
                        input int sda_mode);
      bus_cmd_type c;
      c.action = act;
      c.tx_data = tx;
      c.ack_value = ackv;
      c.sda_in = (sda_mode == SdaHigh);
      push_item(c);
      run_to_idle(sda_mode);
   endtask

   task automatic settle();
      run_to_idle(SdaRand);
      while (checked_cnt < gen_cnt) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_delay(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gen_state.delay = v;
      model_state.delay = v;
   endtask

   task automatic random_traffic(input int n_items);
      bus_cmd_type c;
      int count;
      int r;
      count = 0;
      while (count < n_items) begin
         r = $urandom_range(0, 99);
         if (gen_state.op == OpNone) begin
            if (r < 85) c.action = 3'($urandom_range(ActStart, ActSack));
            else if (r < 93) c.action = ActTick;
            else c.action = ActSpare;
         end else begin
            if (r < 90) c.action = ActTick;
            else if (r < 96) c.action = 3'($urandom_range(ActStart, ActSack));
            else c.action = ActSpare;
         end
         c.tx_data = 8'($urandom);
         c.ack_value = 1'($urandom);
         c.sda_in = 1'($urandom);
         if (gen_state.op != OpNone || (c.action >= ActStart && c.action <= ActSack))
            count++;
         push_item(c);
      end
   endtask

   initial begin
      bus_cmd_type c;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      gen_state = reset_engine();
      model_state = reset_engine();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset delay, then single-tick waits
      issue(ActStart, 8'h00, 1'b0, SdaRand);
      settle();
      set_delay(8'd1);
      issue(ActStart, 8'h00, 1'b0, SdaRand);
      issue(ActWrite, 8'hFF, 1'b0, SdaRand);
      issue(ActWrite, 8'h00, 1'b1, SdaRand);
      issue(ActWack, 8'h00, 1'b0, SdaLow);
      issue(ActWack, 8'hFF, 1'b1, SdaHigh);
      issue(ActRead, 8'h00, 1'b0, SdaHigh);
      issue(ActRead, 8'hFF, 1'b1, SdaLow);
      issue(ActSack, 8'h00, 1'b0, SdaRand);
      issue(ActSack, 8'h00, 1'b1, SdaRand);
      issue(ActStop, 8'h00, 1'b0, SdaRand);
      issue(ActSpare, 8'h5A, 1'b1, SdaHigh);
      issue(ActTick, 8'hA5, 1'b0, SdaLow);
      // a write starts; a read sent while it is busy is dropped but still ticks
      c = '{action: ActWrite, tx_data: 8'hA5, ack_value: 1'b0, sda_in: 1'b1};
      push_item(c);
      c.action = ActRead;
      push_item(c);
      c.action = ActSpare;
      push_item(c);
      run_to_idle(SdaRand);
      settle();

      set_delay(8'd0);
      issue(ActStart, 8'h00, 1'b0, SdaRand);
      issue(ActWrite, 8'($urandom), 1'b0, SdaRand);
      issue(ActStop, 8'h00, 1'b0, SdaRand);
      settle();

      set_delay(8'd255);
      issue(ActStart, 8'h00, 1'b0, SdaRand);
      settle();

      set_delay(8'd2);
      random_traffic(40);
      hold_offs_wanted++;
      settle();
      set_delay(8'd1);
      random_traffic(40);
      hold_offs_wanted++;
      settle();
      set_delay(8'd3);
      random_traffic(40);
      settle();
      set_delay(8'd0);
      random_traffic(40);
      settle();
      set_delay(8'($urandom_range(1, 5)));
      random_traffic(40);
      settle();
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/i2cm_pkg.sv
src/i2cm_req_if.sv
src/i2cm_rsp_if.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_bit_engine.sv
src/i2cm_checker.sv
test/i2c_master_bit_engine_test.sv
